// ----- rtl/dhsf_pkg.sv -----
package dhsf_pkg;

    localparam int Slots    = 16;  // pixel slots in one output beat
    localparam int SlotIdxW = 4;
    localparam int NpixW    = 5;   // holds 1 .. Slots
    localparam int PhaseW   = 11;  // dash/gap run counter, signed
    localparam int RemW     = 10;  // signed phase remainder
    localparam int DivW     = 16;  // magnitude bits of the offset
    localparam int OffsW    = 17;  // signed offset after mirroring
    localparam int CmpW     = 18;  // signed width for clip compares
    localparam int ColorW   = 9;
    localparam int LenW     = 8;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 13;

    localparam logic signed [ColorW-1:0] Transparent = 9'sh1FF;

    typedef enum logic [CfgIdxW-1:0] {
        REG_CLIP_LEFT     = 3'd0,
        REG_CLIP_TOP      = 3'd1,
        REG_CLIP_RIGHT    = 3'd2,
        REG_CLIP_BOTTOM   = 3'd3,
        REG_SURFACE_WIDTH = 3'd4,
        REG_ROW_LIMIT     = 3'd5
    } cfg_idx_t;

    // control from the sequencer to the pattern stepper
    typedef struct packed {
        logic                     load;
        logic signed [PhaseW-1:0] phase;
        logic                     start;
        logic [NpixW-1:0]         npix;
    } grp_ctrl_t;

    // span attributes, stable for the whole span
    typedef struct packed {
        logic signed [ColorW-1:0] dash_color;
        logic signed [ColorW-1:0] gap_color;
        logic [LenW-1:0]          dash_length;
        logic [LenW-1:0]          gap_length;
    } grp_cfg_t;

endpackage

// ----- rtl/dhsf_rem.sv -----
module dhsf_rem
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [dhsf_pkg::OffsW-1:0]   dividend,
    input  logic [dhsf_pkg::LenW:0]             divisor,
    output logic                                done,
    output logic signed [dhsf_pkg::RemW-1:0]    rem
);

    logic                          busy_reg;
    logic                          done_reg;
    logic                          neg_reg;
    logic [4:0]                    cnt_reg;
    logic [dhsf_pkg::DivW-1:0]     dv_reg;
    logic [dhsf_pkg::LenW:0]       m_reg;
    logic [dhsf_pkg::RemW-1:0]     r_reg;

    logic [dhsf_pkg::OffsW-1:0]    mag;
    logic [dhsf_pkg::RemW-1:0]     r_sh;
    logic [dhsf_pkg::RemW-1:0]     r_next;

    // truncated remainder: magnitude divided, sign of the dividend kept
    assign mag    = dividend[dhsf_pkg::OffsW-1] ? 17'(-dividend) : 17'(dividend);
    assign r_sh   = {r_reg[dhsf_pkg::RemW-2:0], dv_reg[dhsf_pkg::DivW-1]};
    assign r_next = (r_sh >= {1'b0, m_reg}) ? (r_sh - {1'b0, m_reg}) : r_sh;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            cnt_reg  <= '0;
            dv_reg   <= '0;
            m_reg    <= '0;
            r_reg    <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg && (cnt_reg == 5'd1);
            if (start)
            begin
                busy_reg <= 1'b1;
                neg_reg  <= dividend[dhsf_pkg::OffsW-1];
                cnt_reg  <= 5'(dhsf_pkg::DivW);
                dv_reg   <= mag[dhsf_pkg::DivW-1:0];
                m_reg    <= divisor;
                r_reg    <= '0;
            end
            else if (busy_reg)
            begin
                r_reg   <= r_next;
                dv_reg  <= {dv_reg[dhsf_pkg::DivW-2:0], 1'b0};
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                    busy_reg <= 1'b0;
            end
        end
    end

    assign done = done_reg;
    assign rem  = neg_reg ? -$signed(r_reg) : $signed(r_reg);

endmodule

// ----- rtl/dhsf_group.sv -----
module dhsf_group
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  dhsf_pkg::grp_ctrl_t   ctrl,
    input  dhsf_pkg::grp_cfg_t    cfg,
    output logic                  done,
    output logic [63:0]           pixels_low,
    output logic [63:0]           pixels_high,
    output logic [15:0]           write_mask
);

    logic                                   busy_reg;
    logic                                   done_reg;
    logic [dhsf_pkg::SlotIdxW-1:0]          idx_reg;
    logic [dhsf_pkg::NpixW-1:0]             npix_reg;
    logic signed [dhsf_pkg::PhaseW-1:0]     phase_reg;
    logic [7:0]                             byte_reg [dhsf_pkg::Slots];
    logic [dhsf_pkg::Slots-1:0]             mask_reg;

    logic                                   in_dash;
    logic signed [dhsf_pkg::PhaseW-1:0]     phase_step;
    logic signed [dhsf_pkg::PhaseW-1:0]     phase_next;
    logic signed [dhsf_pkg::ColorW-1:0]     color;
    logic                                   last_pix;

    // one pixel per cycle: a negative count is inside a dash and counts up,
    // a positive count is inside a gap and counts down
    assign in_dash    = phase_reg[dhsf_pkg::PhaseW-1];
    assign phase_step = in_dash ? (phase_reg + 11'sd1) : (phase_reg - 11'sd1);
    always_comb
    begin
        phase_next = phase_step;
        if (phase_step == '0)
            phase_next = in_dash ? $signed(11'(cfg.gap_length))
                                 : -$signed(11'(cfg.dash_length));
    end
    assign color    = in_dash ? cfg.dash_color : cfg.gap_color;
    assign last_pix = ({1'b0, idx_reg} == (npix_reg - 5'd1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            idx_reg   <= '0;
            npix_reg  <= '0;
            phase_reg <= '0;
        end
        else
        begin
            done_reg <= !ctrl.start && busy_reg && last_pix;
            if (ctrl.load)
                phase_reg <= ctrl.phase;
            else if (busy_reg && !ctrl.start)
                phase_reg <= phase_next;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                idx_reg  <= '0;
                npix_reg <= ctrl.npix;
            end
            else if (busy_reg)
            begin
                idx_reg <= idx_reg + 4'd1;
                if (last_pix)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            for (int i = 0; i < dhsf_pkg::Slots; i++)
                byte_reg[i] <= '0;
            mask_reg <= '0;
        end
        else if (busy_reg && (color != dhsf_pkg::Transparent))
        begin
            byte_reg[idx_reg] <= color[7:0];
            mask_reg[idx_reg] <= 1'b1;
        end
    end

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            pixels_low[8*i +: 8]  = byte_reg[i];
            pixels_high[8*i +: 8] = byte_reg[i+8];
        end
    end

    assign done       = done_reg;
    assign write_mask = mask_reg;

endmodule

// ----- rtl/dashed_hline_span_fill_top.sv -----
// Dashed horizontal span fill. Each input beat is one span command; it is
// checked against the row and column clip registers, ordered left to right
// (a reversed command swaps colors and lengths and mirrors the pattern
// offset), clipped, and then sent out from its left end as beats of up to
// GROUP_PIXELS pixels with a write mask, the final beat flagged by last.
// Rejected commands produce no output beats. Commands are taken one at a
// time: in_ready is high only while the sequencer is idle. Each command is
// accepted, checked, clipped, given its starting phase by the bit-serial
// remainder unit and has that phase loaded; each output beat is then filled
// by the dash/gap stepper at one pixel per cycle and moved into the output
// register once that register is free. A full span of 1024 pixels takes 64
// beats; a rejected command returns to idle from the check or clip step. An
// output beat waits in its own register, so a new command can be accepted
// while the final beat of the previous one waits. Configuration writes are
// taken any time the block is idle.
module dashed_hline_span_fill_top
#(
    parameter int MAX_WIDTH    = 1024,
    parameter int GROUP_PIXELS = 16
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,

    // configuration write port
    input  logic                                  cfg_write,
    input  logic [dhsf_pkg::CfgIdxW-1:0]          cfg_index,
    input  logic [dhsf_pkg::CfgDataW-1:0]         cfg_data,

    // command channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [15:0]                    x_first,
    input  logic signed [15:0]                    x_second,
    input  logic signed [15:0]                    row,
    input  logic signed [8:0]                     dash_color,
    input  logic signed [8:0]                     gap_color,
    input  logic [7:0]                            dash_length,
    input  logic [7:0]                            gap_length,
    input  logic signed [15:0]                    pattern_offset,

    // pixel beat channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [11:0]                           out_row,
    output logic [11:0]                           group_x,
    output logic [63:0]                           pixels_low,
    output logic [63:0]                           pixels_high,
    output logic [15:0]                           write_mask,
    output logic                                  last
);

    localparam int CountW   = 13;
    localparam int CountCap = (MAX_WIDTH < 64 * GROUP_PIXELS) ? MAX_WIDTH
                                                              : 64 * GROUP_PIXELS;
    localparam int CmpW     = dhsf_pkg::CmpW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWAP,
        S_CLIP,
        S_DIV,
        S_PHASE,
        S_GROUP,
        S_WAIT,
        S_EMIT
    } state_t;

    state_t st_reg;

    // clip and surface registers
    logic [11:0]               clip_left_reg;
    logic [11:0]               clip_top_reg;
    logic [12:0]               clip_right_reg;
    logic [12:0]               clip_bottom_reg;
    logic [12:0]               surface_width_reg;
    logic [12:0]               row_limit_reg;

    // command being worked on
    logic signed [15:0]                     xa_reg;
    logic signed [15:0]                     xb_reg;
    logic signed [15:0]                     row_reg;
    logic signed [dhsf_pkg::ColorW-1:0]     dcol_reg;
    logic signed [dhsf_pkg::ColorW-1:0]     gcol_reg;
    logic [dhsf_pkg::LenW-1:0]              dlen_reg;
    logic [dhsf_pkg::LenW-1:0]              glen_reg;
    logic signed [dhsf_pkg::OffsW-1:0]      offs_reg;
    logic [11:0]                            x1_reg;
    logic [CountW-1:0]                      count_reg;
    logic [11:0]                            gx_reg;

    // output beat register
    logic                                   out_valid_reg;
    logic [11:0]                            out_row_reg;
    logic [11:0]                            group_x_reg;
    logic [63:0]                            pixels_low_reg;
    logic [63:0]                            pixels_high_reg;
    logic [15:0]                            write_mask_reg;
    logic                                   last_reg;

    // ---------------------------------------------------------------
    // ordering, row, zero-width and all-transparent checks (S_SWAP)
    // ---------------------------------------------------------------
    logic signed [CmpW-1:0]   row_e;
    logic signed [CmpW-1:0]   xa_e;
    logic signed [CmpW-1:0]   xb_e;
    logic                     reject_swap;
    logic                     reversed;
    logic signed [dhsf_pkg::OffsW-1:0] offs_mirror;

    assign row_e = CmpW'(row_reg);
    assign xa_e  = CmpW'(xa_reg);
    assign xb_e  = CmpW'(xb_reg);

    assign reject_swap = (row_e < signed'(CmpW'(clip_top_reg)))
                      || (row_e >= signed'(CmpW'(clip_bottom_reg)))
                      || (row_e >= signed'(CmpW'(row_limit_reg)))
                      || (xa_reg == xb_reg)
                      || ((dcol_reg == dhsf_pkg::Transparent)
                          && (gcol_reg == dhsf_pkg::Transparent));
    assign reversed    = (xb_e < xa_e);
    // mirrored offset uses the lengths from before the swap
    assign offs_mirror = signed'(17'(glen_reg)) - offs_reg + signed'(17'(dlen_reg));

    // ---------------------------------------------------------------
    // clipping (S_CLIP), ends already ordered
    // ---------------------------------------------------------------
    logic signed [CmpW-1:0]   cl_e;
    logic signed [CmpW-1:0]   cr_e;
    logic signed [CmpW-1:0]   sw_e;
    logic signed [CmpW-1:0]   x1_c;
    logic signed [CmpW-1:0]   x2_c;
    logic signed [CmpW-1:0]   x2_s;
    logic signed [CmpW-1:0]   span_len;
    logic                     reject_clip;

    assign cl_e = signed'(CmpW'(clip_left_reg));
    assign cr_e = signed'(CmpW'(clip_right_reg));
    assign sw_e = signed'(CmpW'(surface_width_reg));

    assign x1_c = (xa_e < cl_e) ? cl_e : xa_e;
    assign x2_c = (xb_e >= cr_e) ? (cr_e - 18'sd1) : xb_e;
    assign x2_s = (x2_c >= sw_e) ? (sw_e - 18'sd1) : x2_c;
    assign span_len = x2_s - x1_c + 18'sd1;

    assign reject_clip = !((xa_e < cr_e) && (cl_e <= xb_e))
                      || (x1_c >= sw_e)
                      || (x2_s < x1_c);

    // ---------------------------------------------------------------
    // starting phase from the truncated remainder
    // ---------------------------------------------------------------
    logic                                   rem_start;
    logic                                   rem_done;
    logic signed [dhsf_pkg::RemW-1:0]       rem;
    logic [dhsf_pkg::LenW:0]                period;
    logic signed [dhsf_pkg::PhaseW-1:0]     rem_e;
    logic signed [dhsf_pkg::PhaseW-1:0]     dlen_e;
    logic signed [dhsf_pkg::PhaseW-1:0]     glen_e;
    logic signed [dhsf_pkg::PhaseW-1:0]     phase_init;

    assign period    = {1'b0, dlen_reg} + {1'b0, glen_reg};
    assign rem_start = (st_reg == S_CLIP) && !reject_clip;

    dhsf_rem u_rem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rem_start),
        .dividend (offs_reg),
        .divisor  (period),
        .done     (rem_done),
        .rem      (rem)
    );

    // inside a dash: count up from phase - dash; inside a gap: count down
    assign rem_e      = dhsf_pkg::PhaseW'(rem);
    assign dlen_e     = signed'(11'(dlen_reg));
    assign glen_e     = signed'(11'(glen_reg));
    assign phase_init = (rem_e < dlen_e) ? (rem_e - dlen_e)
                                         : (dlen_e - rem_e + glen_e);

    // ---------------------------------------------------------------
    // pattern stepper
    // ---------------------------------------------------------------
    dhsf_pkg::grp_ctrl_t      grp_ctrl;
    dhsf_pkg::grp_cfg_t       grp_cfg;
    logic                     grp_done;
    logic [63:0]              grp_lo;
    logic [63:0]              grp_hi;
    logic [15:0]              grp_mask;
    logic [dhsf_pkg::NpixW-1:0] beat_npix;
    logic                     beat_last;

    assign beat_last = (count_reg <= CountW'(GROUP_PIXELS));
    assign beat_npix = beat_last ? count_reg[dhsf_pkg::NpixW-1:0]
                                 : dhsf_pkg::NpixW'(GROUP_PIXELS);

    assign grp_ctrl.load  = (st_reg == S_PHASE);
    assign grp_ctrl.phase = phase_init;
    assign grp_ctrl.start = (st_reg == S_GROUP);
    assign grp_ctrl.npix  = beat_npix;

    assign grp_cfg.dash_color  = dcol_reg;
    assign grp_cfg.gap_color   = gcol_reg;
    assign grp_cfg.dash_length = dlen_reg;
    assign grp_cfg.gap_length  = glen_reg;

    dhsf_group u_group
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (grp_ctrl),
        .cfg         (grp_cfg),
        .done        (grp_done),
        .pixels_low  (grp_lo),
        .pixels_high (grp_hi),
        .write_mask  (grp_mask)
    );

    logic out_free;
    logic beat_load;
    assign out_free  = !out_valid_reg || out_ready;
    // a finished beat moves into the output register
    assign beat_load = (st_reg == S_EMIT) && out_free;

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg     <= 12'd0;
            clip_top_reg      <= 12'd0;
            clip_right_reg    <= 13'd640;
            clip_bottom_reg   <= 13'd480;
            surface_width_reg <= 13'd640;
            row_limit_reg     <= 13'd480;
        end
        else if (cfg_write)
        begin
            unique case (dhsf_pkg::cfg_idx_t'(cfg_index))
                dhsf_pkg::REG_CLIP_LEFT:     clip_left_reg     <= cfg_data[11:0];
                dhsf_pkg::REG_CLIP_TOP:      clip_top_reg      <= cfg_data[11:0];
                dhsf_pkg::REG_CLIP_RIGHT:    clip_right_reg    <= cfg_data;
                dhsf_pkg::REG_CLIP_BOTTOM:   clip_bottom_reg   <= cfg_data;
                dhsf_pkg::REG_SURFACE_WIDTH: surface_width_reg <= cfg_data;
                dhsf_pkg::REG_ROW_LIMIT:     row_limit_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // sequencer and output beat register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg          <= S_IDLE;
            xa_reg          <= '0;
            xb_reg          <= '0;
            row_reg         <= '0;
            dcol_reg        <= '0;
            gcol_reg        <= '0;
            dlen_reg        <= '0;
            glen_reg        <= '0;
            offs_reg        <= '0;
            x1_reg          <= '0;
            count_reg       <= '0;
            gx_reg          <= '0;
            out_valid_reg   <= 1'b0;
            out_row_reg     <= '0;
            group_x_reg     <= '0;
            pixels_low_reg  <= '0;
            pixels_high_reg <= '0;
            write_mask_reg  <= '0;
            last_reg        <= 1'b0;
        end
        else
        begin
            if (beat_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (st_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        xa_reg   <= x_first;
                        xb_reg   <= x_second;
                        row_reg  <= row;
                        dcol_reg <= dash_color;
                        gcol_reg <= gap_color;
                        // a zero length counts as one
                        dlen_reg <= (dash_length == '0) ? 8'd1 : dash_length;
                        glen_reg <= (gap_length == '0) ? 8'd1 : gap_length;
                        offs_reg <= dhsf_pkg::OffsW'(pattern_offset);
                        st_reg   <= S_SWAP;
                    end
                end

                S_SWAP:
                begin
                    if (reject_swap)
                        st_reg <= S_IDLE;
                    else
                    begin
                        if (reversed)
                        begin
                            xa_reg   <= xb_reg;
                            xb_reg   <= xa_reg;
                            dcol_reg <= gcol_reg;
                            gcol_reg <= dcol_reg;
                            dlen_reg <= glen_reg;
                            glen_reg <= dlen_reg;
                            offs_reg <= offs_mirror;
                        end
                        st_reg <= S_CLIP;
                    end
                end

                S_CLIP:
                begin
                    if (reject_clip)
                        st_reg <= S_IDLE;
                    else
                    begin
                        x1_reg    <= x1_c[11:0];
                        count_reg <= span_len[CountW-1:0];
                        st_reg    <= S_DIV;
                    end
                end

                S_DIV:
                begin
                    if (rem_done)
                        st_reg <= S_PHASE;
                end

                S_PHASE:
                begin
                    if (count_reg > CountW'(CountCap))
                        count_reg <= CountW'(CountCap);
                    gx_reg <= x1_reg;
                    st_reg <= S_GROUP;
                end

                S_GROUP:
                begin
                    st_reg <= S_WAIT;
                end

                S_WAIT:
                begin
                    if (grp_done)
                        st_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_row_reg     <= row_reg[11:0];
                        group_x_reg     <= gx_reg;
                        pixels_low_reg  <= grp_lo;
                        pixels_high_reg <= grp_hi;
                        write_mask_reg  <= grp_mask;
                        last_reg        <= beat_last;
                        count_reg       <= count_reg - CountW'(beat_npix);
                        gx_reg          <= gx_reg + 12'(GROUP_PIXELS);
                        st_reg          <= beat_last ? S_IDLE : S_GROUP;
                    end
                end

                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign in_ready    = (st_reg == S_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_row     = out_row_reg;
    assign group_x     = group_x_reg;
    assign pixels_low  = pixels_low_reg;
    assign pixels_high = pixels_high_reg;
    assign write_mask  = write_mask_reg;
    assign last        = last_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------

    // the remainder unit only finishes while the sequencer waits for it
    a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> (st_reg == S_DIV))
        else $error("remainder finished outside the divide wait");

    // a pixel beat only completes while the sequencer waits for it
    a_grp_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        grp_done |-> (st_reg == S_WAIT))
        else $error("pattern stepper finished outside the beat wait");

    // every started beat has pixels left and never exceeds the span cap
    a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_GROUP) |-> ((count_reg != '0)
                                 && (count_reg <= CountW'(CountCap))))
        else $error("pixel count out of range at beat start");

    // no beat is overwritten before it is taken
    a_emit_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == S_EMIT) && out_valid_reg && !out_ready |=>
            (st_reg == S_EMIT))
        else $error("output beat overrun");

endmodule
